### src/point_in_polygon_tester_assert.svh
// Assertion macros shared by the point-in-polygon tester RTL.
`ifndef POINT_IN_POLYGON_TESTER_ASSERT_SVH
`define POINT_IN_POLYGON_TESTER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PIP_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pip_pkg.sv
// Shared constants, types and codes of the point-in-polygon tester.
package pip_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int COORD_BITS   = 16;

    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int IDX_BITS     = 5;
    localparam int CNT_CFG_BITS = 6;
    localparam int RAD_BITS     = COORD_BITS - 1;
    localparam int CFG_IDX_W    = 2;

    localparam int ABS_W = COORD_BITS + 1;
    localparam int DIF_W = COORD_BITS + 2;
    localparam int PRD_W = 2 * DIF_W;
    localparam int DST_W = PRD_W + 1;
    localparam int RSQ_W = 2 * RAD_BITS;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [ABS_W-1:0]      t_abs;
    typedef logic signed [DIF_W-1:0]      t_dif;
    typedef logic signed [PRD_W-1:0]      t_prd;
    typedef logic [DST_W-1:0]             t_dst;
    typedef logic [RSQ_W-1:0]             t_rsq;
    typedef logic [ADDR_W-1:0]            t_addr;
    typedef logic [CNT_W-1:0]             t_cnt;
    typedef logic [RAD_BITS-1:0]          t_radius;
    typedef logic [CNT_CFG_BITS-1:0]      t_count_cfg;

    localparam t_radius    RADIUS_RST = t_radius'(655);
    localparam t_rsq       RSQ_RST    = t_rsq'(655 * 655);
    localparam t_count_cfg COUNT_RST  = t_count_cfg'(16);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X      = 2'd0,
        CFG_ORIGIN_Y      = 2'd1,
        CFG_VERTEX_RADIUS = 2'd2,
        CFG_VERTEX_COUNT  = 2'd3
    } t_cfg_reg;

    // Tag that travels with each vertex read through the edge unit.
    typedef struct packed {
        logic vld;
        logic prime;
        logic last;
    } t_tok;

    typedef struct packed {
        logic done;
        logic in_poly;
        logic near;
    } t_unit_status;

endpackage

### src/pip_ifs.sv
// Handshake channel interfaces: query/vertex input, result output, register writes.
interface pip_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   func;
    logic [pip_pkg::IDX_BITS-1:0]           vertex_index;
    logic signed [pip_pkg::COORD_BITS-1:0]  coord_x;
    logic signed [pip_pkg::COORD_BITS-1:0]  coord_y;

    modport source(output valid, func, vertex_index, coord_x, coord_y, input ready);
    modport sink(input valid, func, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic near_vertex;
    logic close;

    modport source(output valid, inside_res, near_vertex, close, input ready);
    modport sink(input valid, inside_res, near_vertex, close, output ready);
endinterface

interface pip_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [pip_pkg::CFG_IDX_W-1:0]         index;
    logic [pip_pkg::COORD_BITS-1:0]        data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

### src/point_in_polygon_tester.sv
// Top level: register file, query sequencer, vertex table and shared edge unit.
//
//  channel  | dir | payload                                  | transfer when
//  ---------+-----+------------------------------------------+------------------
//  i_in     | in  | func, vertex_index, coord_x, coord_y     | valid && ready
//  o_out    | out | inside_res, near_vertex, close           | valid && ready
//  i_cfg    | in  | index (register), data                   | valid && ready
//
//  A vertex write gives no result.
//  A query makes one table read per vertex in use (at most MAX_VERTICES) plus a primer
//  read of the closing vertex, streamed through the three-stage edge unit, then drain
//  and result load before ready rises again.
//  Reset (synchronous, active low) clears control state and restores register defaults;
//  the vertex table is not cleared. A stalled result holds in the output register.
`include "point_in_polygon_tester_assert.svh"

module point_in_polygon_tester (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pip_in_if.sink    i_in,
    pip_out_if.source o_out,
    pip_cfg_if.sink   i_cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state                 r_state,  n_state;
    pip_pkg::t_cnt          r_cnt,    n_cnt;
    pip_pkg::t_cnt          r_num,    n_num;
    pip_pkg::t_coord        r_cx,     n_cx;
    pip_pkg::t_coord        r_cy,     n_cy;
    logic                   r_out_valid,  n_out_valid;
    logic                   r_out_inside, n_out_inside;
    logic                   r_out_near,   n_out_near;

    pip_pkg::t_coord        r_origin_x;
    pip_pkg::t_coord        r_origin_y;
    pip_pkg::t_rsq          r_radius_sq;
    pip_pkg::t_count_cfg    r_count;

    pip_pkg::t_tok          iss_tok;
    pip_pkg::t_tok          r_tok;
    pip_pkg::t_unit_status  unit_status;

    logic                   in_xfer;
    logic                   cfg_xfer;
    logic                   query_start;
    logic                   wr_en;
    pip_pkg::t_addr         rd_addr;
    pip_pkg::t_cnt          num_sat;
    pip_pkg::t_radius       cfg_radius;
    pip_pkg::t_coord        rd_x;
    pip_pkg::t_coord        rd_y;

    assign in_xfer     = i_in.valid && i_in.ready;
    assign cfg_xfer    = i_cfg.valid && i_cfg.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign query_start = in_xfer && (i_in.func == pip_pkg::FUNC_QUERY);
    assign wr_en       = in_xfer && (i_in.func == pip_pkg::FUNC_WRITE)
                         && (int'(i_in.vertex_index) < pip_pkg::MAX_VERTICES);

    assign num_sat = (int'(r_count) > pip_pkg::MAX_VERTICES)
                     ? pip_pkg::t_cnt'(pip_pkg::MAX_VERTICES) : pip_pkg::t_cnt'(r_count);

    // Register file
    assign cfg_radius = i_cfg.data[pip_pkg::RAD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_radius_sq <= pip_pkg::RSQ_RST;
            r_count     <= pip_pkg::COUNT_RST;
        end else if (cfg_xfer) begin
            case (pip_pkg::t_cfg_reg'(i_cfg.index))
                pip_pkg::CFG_ORIGIN_X:      r_origin_x <= pip_pkg::t_coord'(i_cfg.data);
                pip_pkg::CFG_ORIGIN_Y:      r_origin_y <= pip_pkg::t_coord'(i_cfg.data);
                pip_pkg::CFG_VERTEX_RADIUS: begin
                    // keep the square; only it is compared against
                    r_radius_sq <= pip_pkg::t_rsq'(cfg_radius) * pip_pkg::t_rsq'(cfg_radius);
                end
                pip_pkg::CFG_VERTEX_COUNT:  r_count <= i_cfg.data[pip_pkg::CNT_CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read order: closing vertex n-1 first as primer, then 0 .. n-1
    assign rd_addr = (r_cnt == '0) ? pip_pkg::t_addr'(r_num - pip_pkg::t_cnt'(1))
                                   : pip_pkg::t_addr'(r_cnt - pip_pkg::t_cnt'(1));

    assign iss_tok = '{vld: (r_state == S_RUN), prime: (r_cnt == '0), last: (r_cnt == r_num)};

    pip_vtx_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (pip_pkg::t_addr'(i_in.vertex_index)),
        .i_wr_x    (i_in.coord_x),
        .i_wr_y    (i_in.coord_y),
        .i_rd_addr (rd_addr),
        .o_rd_x    (rd_x),
        .o_rd_y    (rd_y)
    );

    pip_edge_unit u_unit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (query_start),
        .i_tok       (r_tok),
        .i_vx        (rd_x),
        .i_vy        (rd_y),
        .i_origin_x  (r_origin_x),
        .i_origin_y  (r_origin_y),
        .i_cx        (r_cx),
        .i_cy        (r_cy),
        .i_radius_sq (r_radius_sq),
        .o_status    (unit_status)
    );

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_num        = r_num;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_out_valid  = r_out_valid;
        n_out_inside = r_out_inside;
        n_out_near   = r_out_near;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (query_start) begin
                    n_cx    = i_in.coord_x;
                    n_cy    = i_in.coord_y;
                    n_num   = num_sat;
                    n_cnt   = '0;
                    // no vertices in use: cleared accumulators are the answer
                    n_state = (num_sat == '0) ? S_EMIT : S_RUN;
                end
            end
            S_RUN: begin
                n_cnt = r_cnt + pip_pkg::t_cnt'(1);
                if (r_cnt == r_num) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (unit_status.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // load only into a free output register
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_inside = unit_status.in_poly;
                    n_out_near   = unit_status.near;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_tok       <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_tok       <= iss_tok;
        end
        r_num        <= n_num;
        r_cx         <= n_cx;
        r_cy         <= n_cy;
        r_out_inside <= n_out_inside;
        r_out_near   <= n_out_near;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.inside_res  = r_out_inside;
    assign o_out.near_vertex = r_out_near;
    assign o_out.close       = r_out_inside | r_out_near;

    `PIP_ASSERT_HOLDS(a_done_in_drain, unit_status.done, r_state == S_DRAIN, "done outside drain")
    `PIP_ASSERT_HOLDS(a_cnt_bound, r_state == S_RUN, r_cnt <= r_num, "read counter overrun")
    `PIP_ASSERT_NEXT(a_result_held, (r_state == S_EMIT) && r_out_valid && !o_out.ready, r_state == S_EMIT, "result overwritten")
    `PIP_ASSERT_NEXT(a_query_busy, query_start, r_state != S_IDLE, "query did not start")

endmodule

### src/pip_vtx_mem.sv
// Vertex table: x and y stores, one write port, one registered read port.
module pip_vtx_mem (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  pip_pkg::t_addr  i_wr_addr,
    input  pip_pkg::t_coord i_wr_x,
    input  pip_pkg::t_coord i_wr_y,
    input  pip_pkg::t_addr  i_rd_addr,
    output pip_pkg::t_coord o_rd_x,
    output pip_pkg::t_coord o_rd_y
);

    pip_pkg::t_coord r_mem_x [pip_pkg::MAX_VERTICES];
    pip_pkg::t_coord r_mem_y [pip_pkg::MAX_VERTICES];
    pip_pkg::t_coord r_rd_x;
    pip_pkg::t_coord r_rd_y;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_x[i_wr_addr] <= i_wr_x;
            r_mem_y[i_wr_addr] <= i_wr_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_x <= r_mem_x[i_rd_addr];
        r_rd_y <= r_mem_y[i_rd_addr];
    end

    assign o_rd_x = r_rd_x;
    assign o_rd_y = r_rd_y;

endmodule

### src/pip_edge_unit.sv
// Shared edge/vertex unit: offsets, four products, crossing and radius tests, accumulation.
module pip_edge_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  pip_pkg::t_tok         i_tok,
    input  pip_pkg::t_coord       i_vx,
    input  pip_pkg::t_coord       i_vy,
    input  pip_pkg::t_coord       i_origin_x,
    input  pip_pkg::t_coord       i_origin_y,
    input  pip_pkg::t_coord       i_cx,
    input  pip_pkg::t_coord       i_cy,
    input  pip_pkg::t_rsq         i_radius_sq,
    output pip_pkg::t_unit_status o_status
);

    // stage A: absolute vertex and differences
    pip_pkg::t_abs xi;
    pip_pkg::t_abs yi;
    pip_pkg::t_abs cy_abs;
    pip_pkg::t_dif h;
    logic          spans;

    pip_pkg::t_abs r_xj;
    pip_pkg::t_abs r_yj;
    logic          r_a_vld;
    logic          r_a_last;
    logic          r_a_spans;
    logic          r_a_hneg;
    pip_pkg::t_dif r_dx;
    pip_pkg::t_dif r_dy;
    pip_pkg::t_dif r_ex;
    pip_pkg::t_dif r_h;

    // stage B: products
    logic          r_b_vld;
    logic          r_b_last;
    logic          r_b_spans;
    logic          r_b_hneg;
    pip_pkg::t_prd r_pdx2;
    pip_pkg::t_prd r_pdy2;
    pip_pkg::t_prd r_pa;
    pip_pkg::t_prd r_pb;

    // stage C: compare and accumulate
    pip_pkg::t_dst d2;
    logic          near_hit;
    logic          cross_hit;
    logic          r_inside;
    logic          r_near;
    logic          r_done;

    assign xi     = pip_pkg::t_abs'(i_origin_x) + pip_pkg::t_abs'(i_vx);
    assign yi     = pip_pkg::t_abs'(i_origin_y) + pip_pkg::t_abs'(i_vy);
    assign cy_abs = pip_pkg::t_abs'(i_cy);
    assign h      = pip_pkg::t_dif'(r_yj) - pip_pkg::t_dif'(yi);
    assign spans  = ((yi <= cy_abs) && (cy_abs < r_yj)) || ((r_yj <= cy_abs) && (cy_abs < yi));

    always_ff @(posedge i_clk) begin
        if (i_tok.vld) begin
            r_xj <= xi;
            r_yj <= yi;
        end
        r_dx      <= pip_pkg::t_dif'(i_cx) - pip_pkg::t_dif'(xi);
        r_dy      <= pip_pkg::t_dif'(i_cy) - pip_pkg::t_dif'(yi);
        r_ex      <= pip_pkg::t_dif'(r_xj) - pip_pkg::t_dif'(xi);
        r_h       <= h;
        r_a_spans <= spans;
        r_a_hneg  <= h[pip_pkg::DIF_W-1];
        r_a_last  <= i_tok.last;

        r_pdx2    <= r_dx * r_dx;
        r_pdy2    <= r_dy * r_dy;
        r_pa      <= r_dx * r_h;
        r_pb      <= r_ex * r_dy;
        r_b_spans <= r_a_spans;
        r_b_hneg  <= r_a_hneg;
        r_b_last  <= r_a_last;
    end

    // squares are never negative: reinterpret and widen
    assign d2 = pip_pkg::t_dst'($unsigned(r_pdx2)) + pip_pkg::t_dst'($unsigned(r_pdy2));
    assign near_hit  = d2 < pip_pkg::t_dst'(i_radius_sq);
    // edge height sign selects which side of the cross product must be smaller
    assign cross_hit = r_b_hneg ? (r_pb < r_pa) : (r_pa < r_pb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_done   <= 1'b0;
            r_inside <= 1'b0;
            r_near   <= 1'b0;
        end else begin
            // the primer read only loads the previous vertex
            r_a_vld <= i_tok.vld && !i_tok.prime;
            r_b_vld <= r_a_vld;
            r_done  <= r_b_vld && r_b_last;
            if (i_clear) begin
                r_inside <= 1'b0;
                r_near   <= 1'b0;
            end else if (r_b_vld) begin
                r_inside <= r_inside ^ (r_b_spans && cross_hit);
                r_near   <= r_near | near_hit;
            end
        end
    end

    assign o_status = '{done: r_done, in_poly: r_inside, near: r_near};

endmodule

### tb/point_in_polygon_checker.sv
// Checker for the point-in-polygon tester: mirrors its state and scores every result.
module point_in_polygon_checker
    import pip_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pip_in_if    in_ch,
    pip_out_if   out_ch,
    pip_cfg_if   cfg_ch,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic inside_res;
        logic near_vertex;
        logic close;
    } t_hit;

    // Mirror of the block's registers and vertex table
    t_coord     vx_tab [MAX_VERTICES];
    t_coord     vy_tab [MAX_VERTICES];
    t_coord     org_x;
    t_coord     org_y;
    t_radius    grab_radius;
    t_count_cfg used_count;

    t_hit hit_q[$];

    initial o_errors = 0;

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_errors++;
    endtask

    // Crossing-number test plus vertex proximity, all in 64-bit integers.
    function automatic t_hit test_point(t_coord qx, t_coord qy);
        int     n;
        int     j;
        longint px, py, xi, yi, xj, yj, h, dx, dy, r2;
        logic   ins;
        logic   nr;
        t_hit   hit;
        n   = (int'(used_count) > MAX_VERTICES) ? MAX_VERTICES : int'(used_count);
        px  = longint'(qx);
        py  = longint'(qy);
        r2  = longint'(grab_radius) * longint'(grab_radius);
        ins = 1'b0;
        nr  = 1'b0;
        for (int i = 0; i < n; i++) begin
            xi = longint'(org_x) + longint'(vx_tab[i]);
            yi = longint'(org_y) + longint'(vy_tab[i]);
            dx = px - xi;
            dy = py - yi;
            if (dx * dx + dy * dy < r2)
                nr = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            j  = (i == 0) ? n - 1 : i - 1;
            xi = longint'(org_x) + longint'(vx_tab[i]);
            yi = longint'(org_y) + longint'(vy_tab[i]);
            xj = longint'(org_x) + longint'(vx_tab[j]);
            yj = longint'(org_y) + longint'(vy_tab[j]);
            h  = yj - yi;
            // horizontal edges never span, so h is nonzero below
            if ((yi <= py && py < yj) || (yj <= py && py < yi)) begin
                if (h > 0) begin
                    if ((px - xi) * h < (xj - xi) * (py - yi))
                        ins = !ins;
                end else begin
                    if ((xj - xi) * (py - yi) < (px - xi) * h)
                        ins = !ins;
                end
            end
        end
        hit.inside_res  = ins;
        hit.near_vertex = nr;
        hit.close       = ins | nr;
        return hit;
    endfunction

    always @(posedge i_clk) begin
        t_hit want;
        if (!i_rst_n) begin
            org_x       = '0;
            org_y       = '0;
            grab_radius = RADIUS_RST;
            used_count  = COUNT_RST;
            hit_q.delete();
            o_pending <= 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_cfg_reg'(cfg_ch.index))
                    CFG_ORIGIN_X:      org_x = t_coord'(cfg_ch.data);
                    CFG_ORIGIN_Y:      org_y = t_coord'(cfg_ch.data);
                    CFG_VERTEX_RADIUS: grab_radius = cfg_ch.data[RAD_BITS-1:0];
                    CFG_VERTEX_COUNT:  used_count = cfg_ch.data[CNT_CFG_BITS-1:0];
                    default: ;
                endcase
            end
            // retire before accepting, so a result never pairs with a same-edge query
            if (out_ch.valid && out_ch.ready) begin
                if (hit_q.size() == 0) begin
                    report_mismatch("result transfer with no query outstanding");
                end else begin
                    want = hit_q.pop_front();
                    if (out_ch.inside_res !== want.inside_res)
                        report_mismatch($sformatf("inside_res got %b want %b",
                                                  out_ch.inside_res, want.inside_res));
                    if (out_ch.near_vertex !== want.near_vertex)
                        report_mismatch($sformatf("near_vertex got %b want %b",
                                                  out_ch.near_vertex, want.near_vertex));
                    if (out_ch.close !== want.close)
                        report_mismatch($sformatf("close got %b want %b",
                                                  out_ch.close, want.close));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.func == FUNC_WRITE) begin
                    vx_tab[in_ch.vertex_index] = in_ch.coord_x;
                    vy_tab[in_ch.vertex_index] = in_ch.coord_y;
                end else begin
                    hit_q = {hit_q, test_point(in_ch.coord_x, in_ch.coord_y)};
                end
            end
            o_pending <= hit_q.size();
        end
    end

endmodule

### tb/point_in_polygon_tester_test.sv
// Top of the point-in-polygon tester testbench: clock, reset, stimulus and verdict.
module point_in_polygon_tester_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pip_pkg::*;

    localparam int ITEM_GOAL   = 720;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_GAP  = 40;
    localparam int LONG_HOLD   = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pip_in_if  in_ch ();
    pip_out_if out_ch ();
    pip_cfg_if cfg_ch ();

    int mismatches;
    int awaiting;
    int cycle_count = 0;
    int items_sent  = 0;

    bit calm           = 1'b0;
    bit quiet_in       = 1'b0;
    bit want_long_hold = 1'b0;

    // Stimulus-side copy of the polygon, used only to aim queries
    t_coord shape_x [MAX_VERTICES];
    t_coord shape_y [MAX_VERTICES];
    t_coord cur_ox;
    t_coord cur_oy;
    int     cur_rad;
    int     cur_cnt;

    point_in_polygon_tester u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    point_in_polygon_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_ch    (cfg_ch),
        .o_errors  (mismatches),
        .o_pending (awaiting)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request, none at the end
    initial begin : result_sink
        bit hold_done;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (want_long_hold && !hold_done) begin
                out_ch.ready <= 1'b0;
                for (int c = 0; c < LONG_HOLD; c++)
                    @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic t_coord to_coord(int v);
        if (v > 32767)
            return t_coord'(32767);
        if (v < -32768)
            return t_coord'(-32768);
        return t_coord'(v);
    endfunction

    function automatic int spread(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send_item(logic f, logic [IDX_BITS-1:0] slot, t_coord x, t_coord y);
        if (!calm && !quiet_in && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.func         <= f;
        in_ch.vertex_index <= slot;
        in_ch.coord_x      <= x;
        in_ch.coord_y      <= y;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        if (f == FUNC_WRITE) begin
            shape_x[slot] = x;
            shape_y[slot] = y;
        end
        items_sent++;
    endtask

    task automatic query(int x, int y);
        send_item(FUNC_QUERY, '0, to_coord(x), to_coord(y));
    endtask

    task automatic place(int slot, int x, int y);
        send_item(FUNC_WRITE, slot[IDX_BITS-1:0], to_coord(x), to_coord(y));
    endtask

    task automatic cfg_write(t_cfg_reg r, logic [COORD_BITS-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= d;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
    endtask

    task automatic set_registers(int ox, int oy, int rad, int cnt);
        cur_ox  = to_coord(ox);
        cur_oy  = to_coord(oy);
        cur_rad = rad;
        cur_cnt = cnt;
        cfg_write(CFG_ORIGIN_X, cur_ox);
        cfg_write(CFG_ORIGIN_Y, cur_oy);
        cfg_write(CFG_VERTEX_RADIUS, COORD_BITS'(rad));
        cfg_write(CFG_VERTEX_COUNT, COORD_BITS'(cnt));
        cfg_ch.valid <= 1'b0;
    endtask

    // Drop valid, wait for every result, then let any trailing write finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (awaiting != 0)
            @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    // One polygon in a random box, then queries aimed at it, with some noise writes
    task automatic polygon_phase();
        int nv, cx, cy, span, nq, kind, k, off;
        nv   = (cur_cnt > MAX_VERTICES) ? MAX_VERTICES : cur_cnt;
        cx   = spread(16384);
        cy   = spread(16384);
        case ($urandom_range(0, 3))
            0:       span = 256;
            1:       span = 4096;
            2:       span = 16384;
            default: span = 32767;
        endcase
        for (int i = 0; i < nv; i++)
            place(i, cx + spread(span), cy + spread(span));
        nq = $urandom_range(10, 24);
        for (int q = 0; q < nq; q++) begin
            kind = $urandom_range(0, 9);
            if (nv == 0 && (kind == 6 || kind == 7))
                kind = 0;
            k   = (nv > 0) ? $urandom_range(0, nv - 1) : 0;
            off = ($urandom_range(0, 2) == 0) ? 0 : spread(cur_rad);
            case (kind)
                6: query(int'(cur_ox) + int'(shape_x[k]) + off,
                         int'(cur_oy) + int'(shape_y[k]) + spread(cur_rad));
                7: query(int'(cur_ox) + cx + spread(span), int'(cur_oy) + int'(shape_y[k]));
                8: send_item(FUNC_QUERY, IDX_BITS'($urandom), t_coord'($urandom),
                             t_coord'($urandom));
                9: send_item(FUNC_WRITE, IDX_BITS'($urandom), t_coord'($urandom),
                             t_coord'($urandom));
                default: query(int'(cur_ox) + cx + spread(span),
                               int'(cur_oy) + cy + spread(span));
            endcase
        end
    endtask

    initial begin : stimulus
        int phase_no;
        int ox, oy, rad, cnt;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.func         <= FUNC_WRITE;
        in_ch.vertex_index <= '0;
        in_ch.coord_x      <= '0;
        in_ch.coord_y      <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_ORIGIN_X;
        cfg_ch.data        <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Square around the origin with horizontal top and bottom edges
        set_registers(0, 0, 2000, 4);
        place(0, -8192, -8192);
        place(1, 8192, -8192);
        place(2, 8192, 8192);
        place(3, -8192, 8192);
        query(0, 0);
        query(16000, 0);
        query(-8192, -8192);
        query(8692, 8192);
        query(0, -8192);
        query(-8192, 0);
        query(0, 8192);
        query(32767, 32767);
        query(-32768, -32768);
        query(0, -32768);
        settle();
        // No vertices in use: nothing can be hit
        set_registers(0, 0, 2000, 0);
        query(0, 0);
        settle();
        // Single vertex: only proximity can fire
        set_registers(0, 0, 2000, 1);
        query(-8092, -8192);
        settle();
        // Two vertices: a degenerate polygon
        set_registers(0, 0, 2000, 2);
        query(0, -8192);
        query(-8192, -8192);
        settle();
        // Zero radius: an exact vertex hit is not near
        set_registers(0, 0, 0, 4);
        query(8192, 8192);
        query(0, 0);
        settle();
        // Origin at the extremes pushes vertex sums past 16 bits
        set_registers(32767, -32768, 32767, 4);
        query(32767, -32768);
        query(-32768, 32767);
        settle();

        // Fill every slot so any count reads written vertices only
        for (int k = 0; k < MAX_VERTICES; k++)
            send_item(FUNC_WRITE, k[IDX_BITS-1:0], t_coord'($urandom), t_coord'($urandom));
        settle();

        phase_no = 0;
        while (items_sent < ITEM_GOAL) begin
            case (phase_no)
                0: begin ox = 32767;  oy = 32767;  rad = 32767; cnt = 63; end
                1: begin ox = -32768; oy = -32768; rad = 0;     cnt = 32; end
                2: begin ox = 0;      oy = 0;      rad = 655;   cnt = 33; end
                default: begin
                    ox = ($urandom_range(0, 4) == 0) ? 0 : int'(t_coord'($urandom));
                    oy = ($urandom_range(0, 4) == 0) ? 0 : int'(t_coord'($urandom));
                    case ($urandom_range(0, 5))
                        0:       rad = 0;
                        1:       rad = 32767;
                        2:       rad = $urandom_range(0, 32767);
                        default: rad = $urandom_range(1, 4000);
                    endcase
                    case ($urandom_range(0, 9))
                        0:       cnt = $urandom_range(0, 2);
                        1:       cnt = $urandom_range(33, 63);
                        default: cnt = $urandom_range(3, 32);
                    endcase
                end
            endcase
            if (items_sent > ITEM_GOAL - 120)
                calm = 1'b1;
            quiet_in = ($urandom_range(0, 3) == 0);
            if (phase_no == 4)
                want_long_hold = 1'b1;
            set_registers(ox, oy, rad, cnt);
            polygon_phase();
            settle();
            phase_no++;
        end

        if (mismatches == 0 && awaiting == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
